FILE: rtl/ptp_pkg.sv
// Shared types and codes of the payload transfer planner.
package ptp_pkg;

    localparam int OUT_W      = 48;
    localparam int RESULT_CAP = 24;

    localparam logic [1:0] KIND_XFER    = 2'd0;
    localparam logic [1:0] KIND_OFFSET  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_ZERO_LEN = 2'd0;
    localparam logic [1:0] ERR_RANGE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_NO_ALIGN = 2'd3;

    localparam logic [1:0] CFG_OUTPUT_START = 2'd0;
    localparam logic [1:0] CFG_ALIGN_EN     = 2'd1;
    localparam logic [1:0] CFG_ALIGN_SHIFT  = 2'd2;
    localparam logic [1:0] CFG_PLACE_ALIGN  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      src_id;
        logic [OUT_W-1:0] src_off;
        logic [OUT_W-1:0] xfer_len;
        logic [OUT_W-1:0] dst_off;
        logic             xfer_kind;
        logic [31:0]      ext_idx;
        logic [1:0]       err;
        logic [OUT_W-1:0] pad_total;
        logic [OUT_W-1:0] cand_total;
    } rec_t;

endpackage

FILE: rtl/ptp_alu.sv
// Shared adder/subtractor used by the offset, length and range arithmetic of the sequencer.
module ptp_alu #(
    parameter int W = 49
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic         op_sub,
    output logic [W-1:0] result
);
    assign result = op_a + (op_sub ? ~op_b : op_b) + {{(W-1){1'b0}}, op_sub};
endmodule

FILE: rtl/ptp_emit.sv
// Result staging: holds the newest record back until it is known whether it is the last one.
module ptp_emit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic          flush,
    input  ptp_pkg::rec_t push_rec,
    output logic          ok,
    output logic          m_valid,
    input  logic          m_ready,
    output ptp_pkg::rec_t m_rec,
    output logic          m_last
);
    import ptp_pkg::*;

    logic pend_valid_reg;
    logic out_valid_reg;
    logic out_last_reg;
    rec_t pend_reg;
    rec_t out_reg;

    assign ok      = !pend_valid_reg || !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_rec   = out_reg;
    assign m_last  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (push && ok) begin
                if (pend_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= 1'b0;
                end
                pend_valid_reg <= 1'b1;
            end else if (flush && ok && pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && ok) begin
            pend_reg <= push_rec;
            if (pend_valid_reg) begin
                out_reg <= pend_reg;
            end
        end else if (flush && ok && pend_valid_reg) begin
            out_reg <= pend_reg;
        end
    end
endmodule

FILE: rtl/payload_transfer_planner.sv
// Top level of the payload transfer planner: sequencer around one shared adder.
//
//  Channel | Ports        | Direction | Moves
//  --------+--------------+-----------+----------------------------------------
//  input   | s_valid/ready| in        | one extent per transaction
//  result  | m_valid/ready| out       | one record per transaction
//  config  | cfg_valid/rdy| in        | register index and write data
//
// Without a run closing an extent is range checked, tried for a merge, overflow
// checked and buffered; a failed check ends it early, a discarded one is dropped.
// Closing a run works out padding (in aligned placement), destination and end,
// then emits an offset per buffered extent and a plain copy or head, body and tail.
// A new extent is taken only in idle; a stalled result channel stalls the sequencer
// only when a record must be handed on. Reset clears config and control state.
module payload_transfer_planner #(
    parameter int MAX_RUN_SAMPLES = 16,
    parameter int OFFSET_BITS     = 48,
    parameter int MAX_ALIGN_SHIFT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_source_id,
    input  logic [47:0] s_source_size,
    input  logic [47:0] s_extent_offset,
    input  logic [47:0] s_extent_length,
    input  logic        s_last_extent,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [15:0] m_source_id_out,
    output logic [47:0] m_source_offset_out,
    output logic [47:0] m_transfer_length,
    output logic [47:0] m_dest_offset,
    output logic        m_transfer_kind,
    output logic [31:0] m_extent_index,
    output logic [1:0]  m_error_code,
    output logic [47:0] m_padding_total,
    output logic [47:0] m_candidate_total,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import ptp_pkg::*;

    localparam int OW  = (OFFSET_BITS > 48) ? OFFSET_BITS : 48;
    localparam int AW  = OW + 1;
    localparam int CW  = $clog2(MAX_RUN_SAMPLES + 1);
    localparam int IW  = (MAX_RUN_SAMPLES > 1) ? $clog2(MAX_RUN_SAMPLES) : 1;
    localparam int SHW = $clog2(MAX_ALIGN_SHIFT + 1);
    localparam logic [AW-1:0] LIM = (AW'(1) << OFFSET_BITS) - AW'(1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_CHK1    = 5'd2;
    localparam logic [4:0] S_CHK2    = 5'd3;
    localparam logic [4:0] S_MRG     = 5'd4;
    localparam logic [4:0] S_ADD1    = 5'd5;
    localparam logic [4:0] S_ADD2    = 5'd6;
    localparam logic [4:0] S_UPD     = 5'd7;
    localparam logic [4:0] S_FIN     = 5'd8;
    localparam logic [4:0] S_FLUSH   = 5'd9;
    localparam logic [4:0] S_CHEAD   = 5'd10;
    localparam logic [4:0] S_CHMIN   = 5'd11;
    localparam logic [4:0] S_CGAP    = 5'd12;
    localparam logic [4:0] S_CPAD    = 5'd13;
    localparam logic [4:0] S_CDST    = 5'd14;
    localparam logic [4:0] S_CEND    = 5'd15;
    localparam logic [4:0] S_CCOMMIT = 5'd16;
    localparam logic [4:0] S_COFS    = 5'd17;
    localparam logic [4:0] S_XHEAD   = 5'd18;
    localparam logic [4:0] S_XMIN    = 5'd19;
    localparam logic [4:0] S_XEMIT   = 5'd20;
    localparam logic [4:0] S_XSRC    = 5'd21;
    localparam logic [4:0] S_XDST    = 5'd22;
    localparam logic [4:0] S_XLEN    = 5'd23;

    // Configuration.
    logic [47:0] cfg_start_reg;
    logic        cfg_en_reg;
    logic [4:0]  cfg_shift_reg;
    logic        cfg_pa_reg;

    // Control state.
    logic [4:0]    state_reg, state_next;
    logic          run_open_reg, run_open_next;
    logic [CW-1:0] run_cnt_reg, run_cnt_next;
    logic          disc_reg, disc_next;
    logic          list_reg, list_next;
    logic [OW-1:0] pe_reg, pe_next;
    logic [OW-1:0] pad_sum_reg, pad_sum_next;
    logic [OW-1:0] cand_sum_reg, cand_sum_next;
    logic [31:0]   idx_reg, idx_next;
    logic [4:0]    n_reg, n_next;

    // Working values.
    logic [15:0]   in_src_reg, in_src_next;
    logic [47:0]   in_size_reg, in_size_next;
    logic [47:0]   in_off_reg, in_off_next;
    logic [47:0]   in_len_reg, in_len_next;
    logic          in_last_reg, in_last_next;
    logic [15:0]   run_source_reg, run_source_next;
    logic [47:0]   run_src_off_reg, run_src_off_next;
    logic [OW-1:0] run_bytes_reg, run_bytes_next;
    logic [47:0]   len_mem_reg [MAX_RUN_SAMPLES];
    logic [47:0]   len_mem_next [MAX_RUN_SAMPLES];
    logic          err_v_reg, err_v_next;
    logic [1:0]    err_code_reg, err_code_next;
    logic          merge_reg, merge_next;
    logic          ret_end_reg, ret_end_next;
    logic [AW-1:0] tmp_reg, tmp_next;
    logic [OW-1:0] take_reg, take_next;
    logic [OW-1:0] body_reg, body_next;
    logic [OW-1:0] gap_reg, gap_next;
    logic [OW-1:0] pad_reg, pad_next;
    logic [OW-1:0] dst_reg, dst_next;
    logic [OW-1:0] cur_reg, cur_next;
    logic [CW-1:0] i_reg, i_next;
    logic [31:0]   first_reg, first_next;
    logic [47:0]   src_c_reg, src_c_next;
    logic [OW-1:0] len_c_reg, len_c_next;
    logic [1:0]    seg_reg, seg_next;

    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub;
    logic          alu_neg;

    logic [SHW-1:0] s_eff;
    logic [OW-1:0]  mask;
    logic [OW-1:0]  a_val;
    logic [CW-1:0]  cnt_eff;
    logic           mrg;

    logic emit_req, flush_req, emit_ok, need_q, adv;
    rec_t emit_rec, m_rec;

    assign s_eff = (int'(cfg_shift_reg) > MAX_ALIGN_SHIFT) ? SHW'(MAX_ALIGN_SHIFT)
                                                          : SHW'(cfg_shift_reg);
    assign mask  = ~({OW{1'b1}} << s_eff);
    assign a_val = cfg_en_reg ? (OW'(1) << s_eff) : '0;
    assign alu_neg = alu_res[AW-1];

    ptp_alu #(.W(AW)) u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .op_sub (alu_sub),
        .result (alu_res)
    );

    assign need_q = (emit_req && (n_reg < 5'(RESULT_CAP))) || flush_req;
    assign adv    = !need_q || emit_ok;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    ptp_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (emit_req && (n_reg < 5'(RESULT_CAP))),
        .flush    (flush_req),
        .push_rec (emit_rec),
        .ok       (emit_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rec    (m_rec),
        .m_last   (m_last_result)
    );

    assign m_record_kind       = m_rec.kind;
    assign m_source_id_out     = m_rec.src_id;
    assign m_source_offset_out = m_rec.src_off;
    assign m_transfer_length   = m_rec.xfer_len;
    assign m_dest_offset       = m_rec.dst_off;
    assign m_transfer_kind     = m_rec.xfer_kind;
    assign m_extent_index      = m_rec.ext_idx;
    assign m_error_code        = m_rec.err;
    assign m_padding_total     = m_rec.pad_total;
    assign m_candidate_total   = m_rec.cand_total;

    always_comb begin
        state_next       = state_reg;
        run_open_next    = run_open_reg;
        run_cnt_next     = run_cnt_reg;
        disc_next        = disc_reg;
        list_next        = list_reg;
        pe_next          = pe_reg;
        pad_sum_next     = pad_sum_reg;
        cand_sum_next    = cand_sum_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        in_src_next      = in_src_reg;
        in_size_next     = in_size_reg;
        in_off_next      = in_off_reg;
        in_len_next      = in_len_reg;
        in_last_next     = in_last_reg;
        run_source_next  = run_source_reg;
        run_src_off_next = run_src_off_reg;
        run_bytes_next   = run_bytes_reg;
        len_mem_next     = len_mem_reg;
        err_v_next       = err_v_reg;
        err_code_next    = err_code_reg;
        merge_next       = merge_reg;
        ret_end_next     = ret_end_reg;
        tmp_next         = tmp_reg;
        take_next        = take_reg;
        body_next        = body_reg;
        gap_next         = gap_reg;
        pad_next         = pad_reg;
        dst_next         = dst_reg;
        cur_next         = cur_reg;
        i_next           = i_reg;
        first_next       = first_reg;
        src_c_next       = src_c_reg;
        len_c_next       = len_c_reg;
        seg_next         = seg_reg;
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        emit_req  = 1'b0;
        flush_req = 1'b0;
        emit_rec  = '0;
        mrg       = 1'b0;
        cnt_eff   = merge_reg ? run_cnt_reg : '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_src_next  = s_source_id;
                    in_size_next = s_source_size;
                    in_off_next  = s_extent_offset;
                    in_len_next  = s_extent_length;
                    in_last_next = s_last_extent;
                    n_next       = '0;
                    state_next   = S_START;
                end
            end
            S_START: begin
                if (disc_reg) begin
                    if (in_last_reg) begin
                        disc_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end else begin
                    if (!list_reg) begin
                        pe_next        = OW'(cfg_start_reg) & LIM[OW-1:0];
                        pad_sum_next   = '0;
                        cand_sum_next  = '0;
                        idx_next       = '0;
                        run_open_next  = 1'b0;
                        run_cnt_next   = '0;
                        run_bytes_next = '0;
                        list_next      = 1'b1;
                    end
                    err_v_next = 1'b0;
                    merge_next = 1'b0;
                    if (cfg_pa_reg && !cfg_en_reg) begin
                        err_v_next    = 1'b1;
                        err_code_next = ERR_NO_ALIGN;
                        state_next    = S_FIN;
                    end else if (in_len_reg == '0) begin
                        err_v_next    = 1'b1;
                        err_code_next = ERR_ZERO_LEN;
                        state_next    = S_FIN;
                    end else begin
                        state_next = S_CHK1;
                    end
                end
            end
            S_CHK1: begin
                alu_a    = AW'(in_size_reg);
                alu_b    = AW'(in_off_reg);
                alu_sub  = 1'b1;
                tmp_next = alu_res;
                if (alu_neg) begin
                    err_v_next    = 1'b1;
                    err_code_next = ERR_RANGE;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2: begin
                alu_a   = tmp_reg;
                alu_b   = AW'(in_len_reg);
                alu_sub = 1'b1;
                if (alu_neg) begin
                    err_v_next    = 1'b1;
                    err_code_next = ERR_RANGE;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_MRG;
                end
            end
            S_MRG: begin
                alu_a = AW'(run_src_off_reg);
                alu_b = AW'(run_bytes_reg);
                mrg   = run_open_reg && (run_source_reg == in_src_reg)
                        && (alu_res == AW'(in_off_reg));
                merge_next = mrg;
                if (!mrg && run_open_reg) begin
                    ret_end_next = 1'b0;
                    state_next   = S_CHEAD;
                end else begin
                    state_next = S_ADD1;
                end
            end
            S_ADD1: begin
                alu_a      = AW'(pe_reg);
                alu_b      = merge_reg ? AW'(run_bytes_reg) : '0;
                tmp_next   = alu_res;
                state_next = S_ADD2;
            end
            S_ADD2: begin
                alu_a = tmp_reg;
                alu_b = AW'(in_len_reg);
                if (alu_res > LIM) begin
                    err_v_next    = 1'b1;
                    err_code_next = ERR_OVERFLOW;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                alu_a = AW'(run_bytes_reg);
                alu_b = AW'(in_len_reg);
                if (merge_reg) begin
                    run_bytes_next = alu_res[OW-1:0];
                end else begin
                    run_open_next    = 1'b1;
                    run_source_next  = in_src_reg;
                    run_src_off_next = in_off_reg;
                    run_bytes_next   = OW'(in_len_reg);
                end
                if (int'(cnt_eff) < MAX_RUN_SAMPLES) begin
                    len_mem_next[cnt_eff[IW-1:0]] = in_len_reg;
                end
                run_cnt_next = cnt_eff + CW'(1);
                idx_next     = idx_reg + 32'd1;
                if ((int'(cnt_eff) + 1 >= MAX_RUN_SAMPLES) || in_last_reg) begin
                    ret_end_next = 1'b1;
                    state_next   = S_CHEAD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CHEAD: begin
                if (cfg_pa_reg && cfg_en_reg) begin
                    alu_a      = '0;
                    alu_b      = AW'(OW'(run_src_off_reg) & mask);
                    alu_sub    = 1'b1;
                    take_next  = alu_res[OW-1:0] & mask;
                    state_next = S_CHMIN;
                end else begin
                    pad_next   = '0;
                    state_next = S_CDST;
                end
            end
            S_CHMIN: begin
                // Body of the run once the head up to the next boundary is copied.
                alu_a      = AW'(run_bytes_reg);
                alu_b      = AW'(take_reg);
                alu_sub    = 1'b1;
                body_next  = alu_neg ? '0 : (alu_res[OW-1:0] & ~mask);
                state_next = S_CGAP;
            end
            S_CGAP: begin
                alu_a      = AW'(OW'(run_src_off_reg) & mask);
                alu_b      = AW'(pe_reg & mask);
                alu_sub    = 1'b1;
                gap_next   = alu_res[OW-1:0] & mask;
                state_next = S_CPAD;
            end
            S_CPAD: begin
                alu_a      = AW'(gap_reg);
                alu_b      = AW'(body_reg);
                alu_sub    = 1'b1;
                pad_next   = alu_neg ? gap_reg : '0;
                state_next = S_CDST;
            end
            S_CDST: begin
                alu_a    = AW'(pe_reg);
                alu_b    = AW'(pad_reg);
                dst_next = alu_res[OW-1:0];
                // The padding alone can already push the run past the offset limit.
                if (alu_res > LIM) begin
                    if (ret_end_reg) begin
                        idx_next = idx_reg - 32'd1;
                    end
                    err_v_next    = 1'b1;
                    err_code_next = ERR_OVERFLOW;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_CEND;
                end
            end
            S_CEND: begin
                alu_a = AW'(dst_reg);
                alu_b = AW'(run_bytes_reg);
                if (alu_res > LIM) begin
                    if (ret_end_reg) begin
                        idx_next = idx_reg - 32'd1;
                    end
                    err_v_next    = 1'b1;
                    err_code_next = ERR_OVERFLOW;
                    state_next    = S_FIN;
                end else begin
                    pe_next    = alu_res[OW-1:0];
                    state_next = S_CCOMMIT;
                end
            end
            S_CCOMMIT: begin
                alu_a        = AW'(pad_sum_reg);
                alu_b        = AW'(pad_reg);
                pad_sum_next = alu_res[OW-1:0];
                cur_next     = dst_reg;
                i_next       = '0;
                first_next   = idx_reg - 32'(run_cnt_reg);
                src_c_next   = run_src_off_reg;
                len_c_next   = run_bytes_reg;
                state_next   = S_COFS;
            end
            S_COFS: begin
                if (i_reg < run_cnt_reg) begin
                    emit_req         = 1'b1;
                    emit_rec.kind    = KIND_OFFSET;
                    emit_rec.dst_off = cur_reg[OUT_W-1:0];
                    emit_rec.ext_idx = first_reg + 32'(i_reg);
                    alu_a    = AW'(cur_reg);
                    alu_b    = AW'(len_mem_reg[i_reg[IW-1:0]]);
                    cur_next = alu_res[OW-1:0];
                    i_next   = i_reg + CW'(1);
                end else if (!cfg_en_reg
                             || ((OW'(src_c_reg) & mask) != (dst_reg & mask))) begin
                    // Unequal residues: the whole run is one plain copy.
                    seg_next   = 2'd2;
                    take_next  = len_c_reg;
                    state_next = S_XEMIT;
                end else begin
                    seg_next   = 2'd0;
                    state_next = S_XHEAD;
                end
            end
            S_XHEAD: begin
                alu_a      = '0;
                alu_b      = AW'(OW'(src_c_reg) & mask);
                alu_sub    = 1'b1;
                take_next  = alu_res[OW-1:0] & mask;
                state_next = S_XMIN;
            end
            S_XMIN: begin
                alu_a   = AW'(len_c_reg);
                alu_b   = AW'(take_reg);
                alu_sub = 1'b1;
                if (alu_neg) begin
                    take_next = len_c_reg;
                end
                state_next = S_XEMIT;
            end
            S_XEMIT: begin
                if (take_reg != '0) begin
                    emit_req           = 1'b1;
                    emit_rec.kind      = KIND_XFER;
                    emit_rec.src_id    = run_source_reg;
                    emit_rec.src_off   = src_c_reg;
                    emit_rec.xfer_len  = take_reg[OUT_W-1:0];
                    emit_rec.dst_off   = dst_reg[OUT_W-1:0];
                    emit_rec.xfer_kind = (seg_reg == 2'd1);
                end
                alu_a = AW'(cand_sum_reg);
                alu_b = AW'(take_reg);
                if (seg_reg == 2'd1) begin
                    cand_sum_next = alu_res[OW-1:0];
                end
                if (seg_reg == 2'd2) begin
                    run_open_next  = 1'b0;
                    run_cnt_next   = '0;
                    run_bytes_next = '0;
                    state_next     = ret_end_reg ? S_FIN : S_ADD1;
                end else begin
                    state_next = S_XSRC;
                end
            end
            S_XSRC: begin
                alu_a      = AW'(src_c_reg);
                alu_b      = AW'(take_reg);
                src_c_next = alu_res[47:0];
                state_next = S_XDST;
            end
            S_XDST: begin
                alu_a      = AW'(dst_reg);
                alu_b      = AW'(take_reg);
                dst_next   = alu_res[OW-1:0];
                state_next = S_XLEN;
            end
            S_XLEN: begin
                alu_a      = AW'(len_c_reg);
                alu_b      = AW'(take_reg);
                alu_sub    = 1'b1;
                len_c_next = alu_res[OW-1:0];
                if (seg_reg == 2'd0) begin
                    seg_next  = 2'd1;
                    take_next = alu_res[OW-1:0] & ~mask;
                end else begin
                    seg_next  = 2'd2;
                    take_next = alu_res[OW-1:0];
                end
                state_next = S_XEMIT;
            end
            S_FIN: begin
                if (err_v_reg) begin
                    emit_req         = 1'b1;
                    emit_rec.kind    = KIND_ERROR;
                    emit_rec.ext_idx = idx_reg;
                    emit_rec.err     = err_code_reg;
                    run_open_next    = 1'b0;
                    run_cnt_next     = '0;
                    run_bytes_next   = '0;
                    list_next        = 1'b0;
                    disc_next        = !in_last_reg;
                end else if (in_last_reg) begin
                    emit_req            = 1'b1;
                    emit_rec.kind       = KIND_SUMMARY;
                    emit_rec.dst_off    = pe_reg[OUT_W-1:0];
                    emit_rec.pad_total  = pad_sum_reg[OUT_W-1:0];
                    emit_rec.cand_total = cand_sum_reg[OUT_W-1:0];
                    list_next           = 1'b0;
                end
                state_next = S_FLUSH;
            end
            S_FLUSH: begin
                flush_req  = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_req && (n_reg < 5'(RESULT_CAP))) begin
            n_next = n_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_reg <= '0;
            cfg_en_reg    <= 1'b0;
            cfg_shift_reg <= '0;
            cfg_pa_reg    <= 1'b0;
            state_reg     <= S_IDLE;
            run_open_reg  <= 1'b0;
            run_cnt_reg   <= '0;
            disc_reg      <= 1'b0;
            list_reg      <= 1'b0;
            pe_reg        <= '0;
            pad_sum_reg   <= '0;
            cand_sum_reg  <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_OUTPUT_START: cfg_start_reg <= cfg_data;
                    CFG_ALIGN_EN:     cfg_en_reg    <= cfg_data[0];
                    CFG_ALIGN_SHIFT:  cfg_shift_reg <= cfg_data[4:0];
                    CFG_PLACE_ALIGN:  cfg_pa_reg    <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (adv) begin
                state_reg    <= state_next;
                run_open_reg <= run_open_next;
                run_cnt_reg  <= run_cnt_next;
                disc_reg     <= disc_next;
                list_reg     <= list_next;
                pe_reg       <= pe_next;
                pad_sum_reg  <= pad_sum_next;
                cand_sum_reg <= cand_sum_next;
                idx_reg      <= idx_next;
                n_reg        <= n_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_src_reg      <= in_src_next;
            in_size_reg     <= in_size_next;
            in_off_reg      <= in_off_next;
            in_len_reg      <= in_len_next;
            in_last_reg     <= in_last_next;
            run_source_reg  <= run_source_next;
            run_src_off_reg <= run_src_off_next;
            run_bytes_reg   <= run_bytes_next;
            len_mem_reg     <= len_mem_next;
            err_v_reg       <= err_v_next;
            err_code_reg    <= err_code_next;
            merge_reg       <= merge_next;
            ret_end_reg     <= ret_end_next;
            tmp_reg         <= tmp_next;
            take_reg        <= take_next;
            body_reg        <= body_next;
            gap_reg         <= gap_next;
            pad_reg         <= pad_next;
            dst_reg         <= dst_next;
            cur_reg         <= cur_next;
            i_reg           <= i_next;
            first_reg       <= first_next;
            src_c_reg       <= src_c_next;
            len_c_reg       <= len_c_next;
            seg_reg         <= seg_next;
        end
    end
endmodule

FILE: rtl/ptp_checker.sv
// Port-level checks of the payload transfer planner and their binding.
module ptp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_record_kind,
    input logic        m_transfer_kind,
    input logic [47:0] m_dest_offset,
    input logic        m_last_result
);
    import ptp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dest_offset)
                                && $stable(m_record_kind))
        else $error("result changed while stalled");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_record_kind == KIND_SUMMARY || m_record_kind == KIND_ERROR)
        |-> m_last_result)
        else $error("summary or error record not marked last");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_kind != KIND_XFER |-> !m_transfer_kind)
        else $error("transfer kind set on a non-transfer record");
endmodule

bind payload_transfer_planner ptp_checker u_ptp_checker (.*);
